// ----- rtl/core/gfsb_pkg.sv -----
// Shared types, constants and helper functions of the GF(2^8) multiply,
// invert and S-box block. No dependencies.
package gfsb_pkg;

    // Field and S-box constants
    localparam logic [7:0] GF_REDUCE   = 8'h1b;
    localparam logic [7:0] SBOX_CONST  = 8'h63;
    localparam logic [7:0] GF_ONE      = 8'h01;
    localparam logic [7:0] GF_ZERO     = 8'h00;

    // Square-and-multiply rounds for x^254 (x^2 * x^4 * ... * x^128)
    localparam int unsigned INV_ROUNDS = 7;
    localparam int unsigned RND_W      = $clog2(INV_ROUNDS);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(INV_ROUNDS - 1);

    // Operation codes
    typedef enum logic [1:0] {
        CMD_MUL  = 2'd0,
        CMD_INV  = 2'd1,
        CMD_SBOX = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQR,
        ST_ACC,
        ST_DONE
    } t_state;

    // Multiply by x with reduction
    function automatic logic [7:0] gf_xtime(input logic [7:0] v);
        gf_xtime = v[7] ? ({v[6:0], 1'b0} ^ GF_REDUCE) : {v[6:0], 1'b0};
    endfunction

    // Forward AES affine step on an inverted byte
    function automatic logic [7:0] sbox_affine(input logic [7:0] v);
        sbox_affine = v
                    ^ {v[6:0], v[7]}
                    ^ {v[5:0], v[7:6]}
                    ^ {v[4:0], v[7:5]}
                    ^ {v[3:0], v[7:4]}
                    ^ SBOX_CONST;
    endfunction

endpackage

// ----- rtl/core/gfsb_in_if.sv -----
// Input channel of the GF(2^8) block: valid/ready handshake with the
// command and two operand bytes. Depends on nothing.
interface gfsb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] operand_a;
    logic [7:0] operand_b;

    modport source (output valid, output cmd, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input cmd, input operand_a, input operand_b,
                    output ready);
endinterface

// ----- rtl/core/gfsb_out_if.sv -----
// Result channel of the GF(2^8) block: valid/ready handshake with one
// result byte. Depends on nothing.
interface gfsb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;

    modport source (output valid, output result_byte, input ready);
    modport sink   (input valid, input result_byte, output ready);
endinterface

// ----- rtl/core/gfsb_mul.sv -----
// Shared GF(2^8) multiplier: carry-less product reduced by the AES
// polynomial, combinational. Depends on gfsb_pkg.
module gfsb_mul (
    input  logic [7:0] i_a,
    input  logic [7:0] i_b,
    output logic [7:0] o_p
);
    import gfsb_pkg::*;

    // Shift-and-add over the eight bits of i_b
    always_comb begin
        logic [7:0] acc;
        logic [7:0] sh;
        acc = GF_ZERO;
        sh  = i_a;
        for (int k = 0; k < 8; k++) begin
            if (i_b[k]) begin
                acc = acc ^ sh;
            end
            sh = gf_xtime(sh);
        end
        o_p = acc;
    end

endmodule

// ----- rtl/core/gf256_multiply_invert_sbox.sv -----
// GF(2^8) arithmetic unit over x^8+x^4+x^3+x+1 with multiply, inverse and
// forward AES S-box commands. Depends on gfsb_pkg, gfsb_in_if, gfsb_out_if
// and gfsb_mul.
//
// One item is taken at a time and yields one result byte. All field
// products go through a single multiplier under a small sequencer.
// Multiply loads and takes one multiply step; inverse and S-box load and
// run 7 rounds of square then accumulate on the shared multiplier; an
// unknown command loads 0 as its result. The done state then writes the
// result register, with the affine step for S-box. The inverse of 0 is 0,
// so the S-box of 0 is 0x63. A finished result sits in an output register,
// so the next item is accepted while it waits; a stalled output holds the
// sequencer in its final state until the register frees.
module gf256_multiply_invert_sbox (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gfsb_in_if.sink     i_item,
    gfsb_out_if.source  o_result
);
    import gfsb_pkg::*;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [7:0]       r_pow, n_pow;
    logic [7:0]       r_acc, n_acc;
    logic [7:0]       r_b, n_b;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [7:0]       r_res, n_res;
    logic             r_out_valid, n_out_valid;

    logic [7:0] mul_a, mul_b, mul_p;
    logic       in_fire;
    logic       out_free;

    assign i_item.ready         = (r_state == ST_IDLE);
    assign in_fire              = i_item.valid && i_item.ready;
    assign out_free             = !r_out_valid || o_result.ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.result_byte = r_res;

    // Shared multiplier
    gfsb_mul u_mul (
        .i_a (mul_a),
        .i_b (mul_b),
        .o_p (mul_p)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    unique case (t_cmd'(i_item.cmd)) inside
                        CMD_MUL:            n_state = ST_MUL;
                        CMD_INV, CMD_SBOX:  n_state = ST_SQR;
                        default:            n_state = ST_DONE;
                    endcase
                end
            end
            ST_MUL:  n_state = ST_DONE;
            ST_SQR:  n_state = ST_ACC;
            ST_ACC: begin
                n_state = (r_rnd == RND_LAST) ? ST_DONE : ST_SQR;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_cmd       = r_cmd;
        n_pow       = r_pow;
        n_acc       = r_acc;
        n_b         = r_b;
        n_rnd       = r_rnd;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        mul_a       = r_pow;
        mul_b       = r_b;

        // drop the result once taken
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                // load the item
                if (in_fire) begin
                    n_cmd = t_cmd'(i_item.cmd);
                    n_pow = i_item.operand_a;
                    n_b   = i_item.operand_b;
                    n_rnd = '0;
                    n_acc = (t_cmd'(i_item.cmd) == CMD_NONE) ? GF_ZERO : GF_ONE;
                end
            end
            ST_MUL: begin
                mul_a = r_pow;
                mul_b = r_b;
                n_acc = mul_p;
            end
            ST_SQR: begin
                mul_a = r_pow;
                mul_b = r_pow;
                n_pow = mul_p;
            end
            ST_ACC: begin
                mul_a = r_acc;
                mul_b = r_pow;
                n_acc = mul_p;
                n_rnd = r_rnd + 1'b1;
            end
            ST_DONE: begin
                // write the result when the output register is free
                if (out_free) begin
                    n_res       = (r_cmd == CMD_SBOX) ? sbox_affine(r_acc) : r_acc;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_pow <= n_pow;
        r_acc <= n_acc;
        r_b   <= n_b;
        r_rnd <= n_rnd;
        r_res <= n_res;
    end

endmodule
